// ===== hw/rtl/value_frequency_sorter_macros.svh =====
// ----------------------------------------------------------------------------
// Value frequency sorter assertion macros
// Shared assertion forms for the sorter RTL.
// ----------------------------------------------------------------------------
`ifndef VALUE_FREQUENCY_SORTER_MACROS_SVH
`define VALUE_FREQUENCY_SORTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/vfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Value frequency sorter package
// Types, widths and the output ordering rule shared by the cells and the top.
// ----------------------------------------------------------------------------
package vfs_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 7;

  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] value;
    logic [CountW-1:0] count;
  } cell_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INGEST,
    CELL_SORT,
    CELL_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [ValueW-1:0] value;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IN,
    ST_SORT,
    ST_OUT
  } state_e;

  // True when entry a must come before entry b in the output order.
  function automatic logic goes_before(cell_t a, cell_t b);
    logic r;
    if (!a.valid) begin
      r = 1'b0;
    end else if (!b.valid) begin
      r = 1'b1;
    end else if (a.count != b.count) begin
      r = a.count < b.count;
    end else begin
      r = $signed(a.value) < $signed(b.value);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/vfs_cell.sv =====
// ----------------------------------------------------------------------------
// Value frequency sorter cell
// Holds one distinct value and its count; counts, sorts and shifts with its
// neighbors.
// ----------------------------------------------------------------------------
module vfs_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vfs_pkg::cell_cmd_t cmd_i,
  input  vfs_pkg::cell_t    left_i,
  input  vfs_pkg::cell_t    right_i,
  input  logic              pair_lo_i,
  input  logic              pair_hi_i,
  input  logic              hit_any_i,
  output vfs_pkg::cell_t    data_o,
  output logic              hit_o
);
  import vfs_pkg::*;

  cell_t cell_q, cell_d;

  assign hit_o  = cell_q.valid && (cell_q.value == cmd_i.value);
  assign data_o = cell_q;

  always_comb begin
    cell_d = cell_q;
    case (cmd_i.op)
      CELL_INGEST: begin
        if (hit_o) begin
          cell_d.count = cell_q.count + CountW'(1);
        end else if (!cell_q.valid && left_i.valid && !hit_any_i) begin
          cell_d.valid = 1'b1;
          cell_d.value = cmd_i.value;
          cell_d.count = CountW'(1);
        end
      end
      CELL_SORT: begin
        if (pair_lo_i && goes_before(right_i, cell_q)) begin
          cell_d = right_i;
        end else if (pair_hi_i && goes_before(cell_q, left_i)) begin
          cell_d = left_i;
        end
      end
      CELL_SHIFT: cell_d = right_i;
      default:    cell_d = cell_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

endmodule

// ===== hw/rtl/value_frequency_sorter.sv =====
// ----------------------------------------------------------------------------
// Value frequency sorter
// Counts distinct values of a set and emits them by ascending count, then value.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata                                   tuser       tlast
// s_axis   in   [31:0] value                            -           final_item
// m_axis   out  [31:0] distinct_value, [38:32] count    overflowed  last_result
//
// Every cell compares the value of each request at once.
// After the final request the cell row sorts itself by odd-even transposition.
// Results leave the head cell at one per cycle, unless stalled, as the row shifts.
// Reset empties every cell; a stalled result holds the row in place.
// ----------------------------------------------------------------------------
`include "value_frequency_sorter_macros.svh"

module value_frequency_sorter #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic        s_axis_tlast_i,   // final_item
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] distinct_value, [38:32] occurrences
  output logic        m_axis_tuser_o,   // overflowed
  output logic        m_axis_tlast_o    // last_result
);
  import vfs_pkg::*;

  localparam int unsigned TakenW = $clog2(CAPACITY + 1);

  state_e            state_q, state_d;
  logic [TakenW-1:0] taken_q, taken_d;
  logic [TakenW-1:0] pass_q, pass_d;
  logic              drop_q, drop_d;
  logic              phase_q, phase_d;
  cell_cmd_t         cmd;
  cell_t             cells [CAPACITY];
  cell_t             left_of [CAPACITY];
  cell_t             right_of [CAPACITY];
  logic [CAPACITY-1:0] hits, pair_lo, pair_hi;
  logic              in_fire, out_fire, full;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign full     = (taken_q == TakenW'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_of[i] = '{valid: 1'b1, value: '0, count: '0};
    end else begin : g_mid
      assign left_of[i] = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_of[i] = '0;
    end else begin : g_body
      assign right_of[i] = cells[i+1];
    end
    assign pair_lo[i] = (i < CAPACITY - 1) && ((i % 2 == 1) == phase_q);
    assign pair_hi[i] = (i > 0) && (((i - 1) % 2 == 1) == phase_q);

    vfs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_i    (left_of[i]),
      .right_i   (right_of[i]),
      .pair_lo_i (pair_lo[i]),
      .pair_hi_i (pair_hi[i]),
      .hit_any_i (|hits),
      .data_o    (cells[i]),
      .hit_o     (hits[i])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IN:   if (in_fire && s_axis_tlast_i) state_d = ST_SORT;
      ST_SORT: if (pass_q == TakenW'(1)) state_d = ST_OUT;
      ST_OUT:  if (out_fire && m_axis_tlast_o) state_d = ST_IN;
      default: state_d = ST_IN;
    endcase
  end

  always_comb begin
    cmd.op    = CELL_HOLD;
    cmd.value = s_axis_tdata_i;
    taken_d   = taken_q;
    drop_d    = drop_q;
    pass_d    = pass_q;
    phase_d   = phase_q;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    case (state_q)
      ST_IN: begin
        s_axis_tready_o = 1'b1;
        pass_d  = TakenW'(CAPACITY);
        phase_d = 1'b0;
        if (in_fire) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            cmd.op  = CELL_INGEST;
            taken_d = taken_q + TakenW'(1);
          end
        end
      end
      ST_SORT: begin
        cmd.op  = CELL_SORT;
        pass_d  = pass_q - TakenW'(1);
        phase_d = !phase_q;
      end
      ST_OUT: begin
        m_axis_tvalid_o = 1'b1;
        if (out_fire) begin
          cmd.op = CELL_SHIFT;
          if (m_axis_tlast_o) begin
            taken_d = '0;
            drop_d  = 1'b0;
          end
        end
      end
      default: cmd.op = CELL_HOLD;
    endcase
  end

  assign m_axis_tdata_o = {1'b0, cells[0].count, cells[0].value};
  assign m_axis_tuser_o = drop_q;
  assign m_axis_tlast_o = (CAPACITY == 1) ? 1'b1 : !right_of[0].valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IN;
      taken_q <= '0;
      pass_q  <= '0;
      drop_q  <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      taken_q <= taken_d;
      pass_q  <= pass_d;
      drop_q  <= drop_d;
      phase_q <= phase_d;
    end
  end

  `VFS_ASSERT_NOW(a_out_head_valid, m_axis_tvalid_o, cells[0].valid && cells[0].count != '0, "result from an empty cell")
  `VFS_ASSERT_NOW(a_taken_bound, 1'b1, taken_q <= TakenW'(CAPACITY), "kept item count beyond capacity")
  `VFS_ASSERT_NOW(a_one_hit, state_q == ST_IN, $onehot0(hits), "value held in two cells")
  `VFS_ASSERT_NEXT(a_final_sorts, in_fire && s_axis_tlast_i, state_q == ST_SORT, "final request did not start the sort")

endmodule
